// ----- hw/rtl/lbbp_pkg.sv -----
// Shared types, constants and helper functions for the LRU byte budget pool.
package lbbp_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 32;
  localparam int BYTES_W = 31;
  localparam int SUM_W = 37;
  localparam int OCNT_W = 7;

  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_RESERVE = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_PUBLISH = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [2:0] CMD_HOLD   = 3'd0;
  localparam logic [2:0] CMD_MOVE   = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_ERASE  = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic               cached;
    logic               leased;
  } entry_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] pos;
    entry_t           ent;
  } cmd_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCNT_W-1:0] w;
    w = (CNT_W + OCNT_W)'(c);
    return (w > (CNT_W + OCNT_W)'(127)) ? OCNT_W'(127) : w[OCNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/lbbp_cell.sv -----
// One recency position of the entry chain, shifting entries with its neighbors.
module lbbp_cell
  import lbbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  cmd_t             cmd,
  input  logic [KEY_W-1:0] key,
  input  entry_t           below,
  input  entry_t           above,
  output entry_t           ent,
  output logic             hit
);

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.kind)
      CMD_MOVE: begin
        if (idx == '0) begin
          ent_nxt = cmd.ent;
        end else if (idx <= cmd.pos) begin
          ent_nxt = below;
        end
      end
      CMD_INSERT: begin
        if (idx == '0) begin
          ent_nxt = cmd.ent;
        end else begin
          ent_nxt = below;
        end
      end
      CMD_ERASE: begin
        if (idx >= cmd.pos) begin
          ent_nxt = above;
        end
      end
      CMD_UPDATE: begin
        if (idx == cmd.pos) begin
          ent_nxt.cached = cmd.ent.cached;
          ent_nxt.leased = cmd.ent.leased;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;
  assign hit = ent_r.valid && (ent_r.key == key);

endmodule

// ----- hw/rtl/lru_byte_budget_pool_top.sv -----
// Top level of the LRU byte budget pool: control, totals and the entry chain.
// Acquire, remove and release go through lookup, action and finish states after acceptance;
// cancel, publish and unknown ops skip lookup; reserve goes through init, an eviction
// walk from the least recent occupied position, and done. Finish waits while the output
// is stalled. One word is in flight, so a new word is taken only once the result goes out.
// Synchronous active-low reset empties the chain, clears totals and counts,
// and restores the budget to 67108864 bytes; no clearing pass is needed.
module lru_byte_budget_pool_top
  import lbbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [BYTES_W-1:0]  in_item_bytes,
  input  logic [BYTES_W-1:0]  in_reserve_bytes,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [KEY_W-1:0]    out_key_out,
  output logic [OCNT_W-1:0]   out_evicted_count,
  output logic [SUM_W-1:0]    out_resident_bytes,
  output logic [SUM_W-1:0]    out_reserved_total,
  output logic [OCNT_W-1:0]   out_cached_count,
  output logic [OCNT_W-1:0]   out_leased_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_RINIT = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_RDONE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]             state_r;
  logic [2:0]             op_r;
  logic [KEY_W-1:0]       key_r;
  logic [BYTES_W-1:0]     item_r;
  logic [BYTES_W-1:0]     rsv_r;
  logic [MAX_ENTRIES-1:0] match_r;
  logic [SUM_W:0]         rs_r;
  logic [IDX_W-1:0]       p_r;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       cached_cnt_r;
  logic [CNT_W-1:0]       leased_cnt_r;
  logic [CNT_W-1:0]       evict_r;
  logic [SUM_W-1:0]       resident_r;
  logic [SUM_W-1:0]       reserved_r;
  logic [SUM_W-1:0]       budget_r;
  logic [KEY_W-1:0]       last_key_r;
  logic [1:0]             status_r;
  logic [KEY_W-1:0]       key_out_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [KEY_W-1:0]       out_key_out_r;
  logic [OCNT_W-1:0]      out_evicted_count_r;
  logic [SUM_W-1:0]       out_resident_bytes_r;
  logic [SUM_W-1:0]       out_reserved_total_r;
  logic [OCNT_W-1:0]      out_cached_count_r;
  logic [OCNT_W-1:0]      out_leased_count_r;

  entry_t                 ents [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hits;
  cmd_t                   cmd;
  entry_t                 tgt;
  logic [IDX_W-1:0]       first_idx;
  logic [IDX_W-1:0]       sel_idx;
  logic                   any_hit;
  logic                   full;
  logic                   over;
  logic                   accept;
  logic                   out_free;
  logic [KEY_W-1:0]       new_key;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = ents[MAX_ENTRIES-1].valid;
  assign any_hit  = |match_r;
  assign new_key  = last_key_r + 1'b1;
  assign over     = ({2'b0, resident_r} + {1'b0, rs_r}) > {2'b0, budget_r};
  assign sel_idx  = (state_r == S_WALK) ? p_r : first_idx;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      entry_t below_w;
      entry_t above_w;
      if (g == 0) begin : g_first
        assign below_w = '0;
      end else begin : g_mid_lo
        assign below_w = ents[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_last
        assign above_w = '0;
      end else begin : g_mid_hi
        assign above_w = ents[g+1];
      end
      lbbp_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (IDX_W'(g)),
        .cmd   (cmd),
        .key   (key_r),
        .below (below_w),
        .above (above_w),
        .ent   (ents[g]),
        .hit   (hits[g])
      );
    end
  endgenerate

  always_comb begin
    first_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    tgt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        tgt = tgt | ents[i];
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_HOLD;
    cmd.pos  = sel_idx;
    cmd.ent  = tgt;
    if (state_r == S_ACT) begin
      case (op_r)
        OP_ACQUIRE: begin
          if (any_hit && tgt.cached) begin
            cmd.kind       = CMD_MOVE;
            cmd.ent.leased = 1'b1;
          end
        end
        OP_PUBLISH: begin
          if (!full) begin
            cmd.kind = CMD_INSERT;
            cmd.ent  = '{valid: 1'b1, key: new_key, bytes: item_r,
                         cached: 1'b1, leased: 1'b1};
          end
        end
        OP_REMOVE: begin
          if (any_hit && tgt.cached) begin
            cmd.kind       = tgt.leased ? CMD_UPDATE : CMD_ERASE;
            cmd.ent.cached = 1'b0;
          end
        end
        OP_RELEASE: begin
          if (any_hit && tgt.leased) begin
            cmd.kind       = tgt.cached ? CMD_MOVE : CMD_ERASE;
            cmd.ent.leased = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (state_r == S_WALK) begin
      if (over && tgt.valid && !tgt.leased) begin
        cmd.kind = CMD_ERASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= '0;
      cached_cnt_r <= '0;
      leased_cnt_r <= '0;
      resident_r   <= '0;
      reserved_r   <= '0;
      last_key_r   <= '0;
      budget_r     <= SUM_W'(67108864);
      out_valid_r  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && !paddr[3]) begin
        budget_r <= pwdata[SUM_W-1:0];
      end
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_op;
            key_r    <= in_key;
            item_r   <= in_item_bytes;
            rsv_r    <= in_reserve_bytes;
            evict_r  <= '0;
            key_out_r <= '0;
            status_r <= ST_MISS;
            if (in_op == OP_RESERVE) begin
              state_r <= S_RINIT;
            end else if (in_op == OP_ACQUIRE || in_op == OP_REMOVE ||
                         in_op == OP_RELEASE) begin
              state_r <= S_LOOK;
            end else begin
              state_r <= S_ACT;
            end
          end
        end
        S_LOOK: begin
          match_r <= hits;
          state_r <= S_ACT;
        end
        S_ACT: begin
          state_r <= S_FIN;
          case (op_r)
            OP_ACQUIRE: begin
              if (any_hit && tgt.cached) begin
                status_r <= ST_DONE;
                if (!tgt.leased) begin
                  leased_cnt_r <= leased_cnt_r + 1'b1;
                end
              end
            end
            OP_CANCEL: begin
              status_r   <= ST_DONE;
              reserved_r <= sat_sub(reserved_r, SUM_W'(rsv_r));
            end
            OP_PUBLISH: begin
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                status_r     <= ST_DONE;
                last_key_r   <= new_key;
                key_out_r    <= new_key;
                n_r          <= n_r + 1'b1;
                cached_cnt_r <= cached_cnt_r + 1'b1;
                leased_cnt_r <= leased_cnt_r + 1'b1;
                resident_r   <= sat_add(resident_r, SUM_W'(item_r));
                reserved_r   <= sat_sub(reserved_r, SUM_W'(rsv_r));
              end
            end
            OP_REMOVE: begin
              if (any_hit && tgt.cached) begin
                status_r     <= ST_DONE;
                cached_cnt_r <= cached_cnt_r - 1'b1;
                if (!tgt.leased) begin
                  n_r        <= n_r - 1'b1;
                  resident_r <= sat_sub(resident_r, SUM_W'(tgt.bytes));
                end
              end
            end
            OP_RELEASE: begin
              if (any_hit && tgt.leased) begin
                status_r     <= ST_DONE;
                leased_cnt_r <= leased_cnt_r - 1'b1;
                if (!tgt.cached) begin
                  n_r        <= n_r - 1'b1;
                  resident_r <= sat_sub(resident_r, SUM_W'(tgt.bytes));
                end
              end
            end
            default: ;
          endcase
        end
        S_RINIT: begin
          rs_r     <= {1'b0, reserved_r} + (SUM_W + 1)'(rsv_r);
          status_r <= ST_DONE;
          p_r      <= IDX_W'(n_r - 1'b1);
          state_r  <= (n_r == '0) ? S_RDONE : S_WALK;
        end
        S_WALK: begin
          if (!over) begin
            state_r <= S_RDONE;
          end else begin
            if (tgt.valid && !tgt.leased) begin
              n_r        <= n_r - 1'b1;
              evict_r    <= evict_r + 1'b1;
              resident_r <= sat_sub(resident_r, SUM_W'(tgt.bytes));
              if (tgt.cached) begin
                cached_cnt_r <= cached_cnt_r - 1'b1;
              end
            end
            if (p_r == '0) begin
              state_r <= S_RDONE;
            end else begin
              p_r <= p_r - 1'b1;
            end
          end
        end
        S_RDONE: begin
          reserved_r <= rs_r[SUM_W] ? {SUM_W{1'b1}} : rs_r[SUM_W-1:0];
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_status_r         <= status_r;
            out_key_out_r        <= key_out_r;
            out_evicted_count_r  <= sat_cnt(evict_r);
            out_resident_bytes_r <= resident_r;
            out_reserved_total_r <= reserved_r;
            out_cached_count_r   <= sat_cnt(cached_cnt_r);
            out_leased_count_r   <= sat_cnt(leased_cnt_r);
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_key_out        = out_key_out_r;
  assign out_evicted_count  = out_evicted_count_r;
  assign out_resident_bytes = out_resident_bytes_r;
  assign out_reserved_total = out_reserved_total_r;
  assign out_cached_count   = out_cached_count_r;
  assign out_leased_count   = out_leased_count_r;
  assign pready    = 1'b1;
  assign prdata    = paddr[3] ? 64'd0 : {{(64 - SUM_W){1'b0}}, budget_r};

`ifndef ASSERT_OFF
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cached_cnt_r <= n_r) && (leased_cnt_r <= n_r))
    else $error("cached or leased count exceeds entry count");

  a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    full == (n_r == CNT_W'(MAX_ENTRIES)))
    else $error("last chain position disagrees with entry count");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ({1'b0, p_r} < n_r + 1'b1))
    else $error("eviction walk beyond occupied positions");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted word did not start an operation");
`endif

endmodule
